>>> hw/rtl/gepp_pkg.sv
// shared constants and helpers for the linear-system solver
package gepp_pkg;

    localparam int MAX_N     = 16;
    localparam int STRIDE    = MAX_N + 1;
    localparam int DEPTH     = MAX_N * STRIDE;
    localparam int AW        = $clog2(DEPTH);
    localparam int IW        = $clog2(MAX_N + 1);
    localparam int SIZE_W    = 5;
    localparam int LOAD_W    = 9;
    localparam int DIV_STEPS = 64;

    // saturate a 64-bit signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sh7FFF_FFFF)
            r = 32'sh7FFF_FFFF;
        else if (v < -64'sh8000_0000)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

    // magnitude of a 32-bit signed value, 33 bits wide
    function automatic logic [32:0] mag33(input logic signed [31:0] v);
        logic signed [32:0] w;
        w = {v[31], v};
        return w[32] ? 33'(-w) : 33'(w);
    endfunction

    // product of two q16.16 values divided by one, truncated toward zero
    function automatic logic signed [63:0] mulq_fix(input logic signed [63:0] p);
        logic signed [63:0] q;
        q = p >>> 16;
        if (p[63] && (p[15:0] != 16'd0))
            q = q + 64'sd1;
        return q;
    endfunction

    // address of row r, column c
    function automatic logic [AW-1:0] addr_of(input logic [IW-1:0] r,
                                              input logic [IW-1:0] c);
        logic [AW+IW-1:0] a;
        a = (AW+IW)'(r) * (AW+IW)'(STRIDE) + (AW+IW)'(c);
        return a[AW-1:0];
    endfunction

endpackage

>>> hw/rtl/gaussian_elim_partial_pivot.sv
// gaussian elimination with partial pivoting: loader, sequencer and result queue
// throughput: one item per cycle while loading with no size write, then not ready until all n results are taken
// the single matrix memory and the bit-serial divider set the solve time
// reset: control state cleared, size 16, load count 0; matrix store is not cleared
module gaussian_elim_partial_pivot (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [4:0]          cfg_wdata,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic signed [31:0]  coefficient,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [31:0]  solution,
    output logic [3:0]          solution_index,
    output logic                last_solution,
    output logic                singular
);
    import gepp_pkg::*;

    typedef enum logic [4:0] {
        S_LOAD, S_PIV_RD, S_PIV_CMP, S_SWP_RD1, S_SWP_RD2, S_SWP_WR,
        S_PV_RD, S_PV_CHK, S_F_RD, S_F_DIV, S_F_WAIT,
        S_E_RD1, S_E_RD2, S_E_MUL, S_E_WR,
        S_B_RD, S_B_CHK, S_B_RD1, S_B_RD2, S_B_MUL, S_B_SUB,
        S_B_DIV, S_B_WAIT, S_OUT_RD, S_OUT
    } state_t;

    logic signed [31:0] mem [DEPTH];
    logic signed [31:0] rd_data;
    logic [AW-1:0]      rd_addr, wr_addr;
    logic               wr_en;
    logic signed [31:0] wr_data;

    state_t state_reg;
    logic [IW-1:0] n_reg, i_reg, j_reg, k_reg, r_reg, lr_reg, lc_reg;
    logic [LOAD_W-1:0] cnt_reg;
    logic signed [31:0] best_reg, t_reg, p_reg, f_reg, acc_reg;
    logic signed [63:0] prod_reg;
    logic sing_reg, ov_reg;
    logic [IW-1:0] cfg_n;

    logic div_start;
    logic signed [63:0] div_num;
    logic div_done;
    logic signed [31:0] div_q;

    gepp_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_num),
        .divisor(p_reg), .done(div_done), .quotient(div_q)
    );

    assign cfg_n = (cfg_wdata == 5'd0) ? IW'(1) :
                   (cfg_wdata > 5'(MAX_N)) ? IW'(MAX_N) : IW'(cfg_wdata);

    // matrix memory, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data <= mem[rd_addr];
    end

    // memory address, write and divider control
    always_comb
    begin
        rd_addr   = addr_of(i_reg, k_reg);
        wr_addr   = addr_of(i_reg, k_reg);
        wr_en     = 1'b0;
        wr_data   = t_reg;
        div_start = 1'b0;
        div_num   = {{16{acc_reg[31]}}, acc_reg, 16'd0};
        unique case (state_reg)
            S_LOAD:
            begin
                wr_addr = addr_of(lr_reg, lc_reg);
                wr_en   = in_valid && in_ready;
                wr_data = coefficient;
            end
            S_PIV_RD:  rd_addr = addr_of(j_reg, i_reg);
            S_SWP_RD1: rd_addr = addr_of(i_reg, k_reg);
            S_SWP_RD2: rd_addr = addr_of(r_reg, k_reg);
            S_SWP_WR:
            begin
                // rd_data holds A(r,k): write it at row i, then A(i,k) at row r
                wr_en   = 1'b1;
                wr_addr = addr_of(i_reg, k_reg);
                wr_data = rd_data;
            end
            S_PV_RD:   rd_addr = addr_of(i_reg, i_reg);
            S_F_RD:    rd_addr = addr_of(j_reg, i_reg);
            S_F_DIV:
            begin
                div_start = 1'b1;
                div_num   = {{16{rd_data[31]}}, rd_data, 16'd0};
            end
            S_E_RD1:   rd_addr = addr_of(i_reg, k_reg);
            S_E_RD2:   rd_addr = addr_of(j_reg, k_reg);
            S_E_WR:
            begin
                wr_en   = 1'b1;
                wr_addr = addr_of(j_reg, k_reg);
                wr_data = sat32(64'(t_reg) - mulq_fix(prod_reg));
            end
            S_B_RD:    rd_addr = addr_of(i_reg, n_reg);
            S_B_CHK:   rd_addr = addr_of(i_reg, i_reg);
            S_B_RD1:   rd_addr = addr_of(i_reg, j_reg);
            S_B_RD2:   rd_addr = addr_of(j_reg, n_reg);
            // diagonal again, so the next pass sees the pivot
            S_B_SUB:   rd_addr = addr_of(i_reg, i_reg);
            S_B_DIV:   div_start = 1'b1;
            S_B_WAIT:
            begin
                wr_en   = div_done;
                wr_addr = addr_of(i_reg, n_reg);
                wr_data = div_q;
            end
            S_OUT_RD:  rd_addr = addr_of(i_reg, n_reg);
            // keep the result word on the read port while it waits
            S_OUT:     rd_addr = addr_of(i_reg, n_reg);
            default:   ;
        endcase
    end

    assign in_ready  = (state_reg == S_LOAD) && !cfg_we;
    assign out_valid = (state_reg == S_OUT);
    assign solution  = sing_reg ? 32'sd0 : rd_data;
    assign solution_index = i_reg[3:0];
    assign last_solution  = (i_reg == n_reg - IW'(1));
    assign singular       = sing_reg;

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            n_reg     <= IW'(MAX_N);
            cnt_reg   <= '0;
            lr_reg    <= '0;
            lc_reg    <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            r_reg     <= '0;
            sing_reg  <= 1'b0;
            ov_reg    <= 1'b0;
            best_reg  <= '0;
            t_reg     <= '0;
            p_reg     <= '0;
            f_reg     <= '0;
            acc_reg   <= '0;
            prod_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_LOAD:
                begin
                    if (cfg_we)
                    begin
                        n_reg   <= cfg_n;
                        cnt_reg <= '0;
                        lr_reg  <= '0;
                        lc_reg  <= '0;
                    end
                    else if (in_valid)
                    begin
                        if (cnt_reg + LOAD_W'(1) == LOAD_W'(n_reg) * LOAD_W'(n_reg + IW'(1)))
                        begin
                            cnt_reg  <= '0;
                            lr_reg   <= '0;
                            lc_reg   <= '0;
                            sing_reg <= 1'b0;
                            i_reg    <= '0;
                            if (n_reg == IW'(1))
                                state_reg <= S_B_RD;
                            else
                            begin
                                r_reg     <= '0;
                                j_reg     <= '0;
                                best_reg  <= '0;
                                state_reg <= S_PIV_RD;
                            end
                        end
                        else
                        begin
                            if (lc_reg == n_reg)
                            begin
                                lc_reg <= '0;
                                lr_reg <= lr_reg + IW'(1);
                            end
                            else
                                lc_reg <= lc_reg + IW'(1);
                            cnt_reg <= cnt_reg + LOAD_W'(1);
                        end
                    end
                end
                // pivot search: scan rows i..n-1 of column i
                S_PIV_RD: state_reg <= S_PIV_CMP;
                S_PIV_CMP:
                begin
                    if (j_reg == i_reg || mag33(rd_data) > mag33(best_reg))
                    begin
                        best_reg <= rd_data;
                        r_reg    <= j_reg;
                    end
                    if (j_reg == n_reg - IW'(1))
                    begin
                        k_reg     <= i_reg;
                        state_reg <= S_SWP_RD1;
                    end
                    else
                    begin
                        j_reg     <= j_reg + IW'(1);
                        state_reg <= S_PIV_RD;
                    end
                end
                // row swap, one column per pass
                S_SWP_RD1:
                begin
                    if (r_reg == i_reg)
                        state_reg <= S_PV_RD;
                    else
                        state_reg <= S_SWP_RD2;
                end
                S_SWP_RD2:
                begin
                    t_reg     <= rd_data;
                    state_reg <= S_SWP_WR;
                end
                S_SWP_WR:
                begin
                    // second half: old A(i,k) goes to row r via the elim write path
                    j_reg     <= r_reg;
                    prod_reg  <= '0;
                    state_reg <= S_E_WR;
                    ov_reg    <= 1'b1;
                end
                S_PV_RD: state_reg <= S_PV_CHK;
                S_PV_CHK:
                begin
                    p_reg <= rd_data;
                    if (rd_data == 32'sd0)
                    begin
                        sing_reg  <= 1'b1;
                        i_reg     <= '0;
                        state_reg <= S_OUT_RD;
                    end
                    else
                    begin
                        j_reg     <= i_reg + IW'(1);
                        state_reg <= S_F_RD;
                    end
                end
                // factor for row j
                S_F_RD: state_reg <= S_F_DIV;
                S_F_DIV: state_reg <= S_F_WAIT;
                S_F_WAIT:
                begin
                    if (div_done)
                    begin
                        f_reg     <= div_q;
                        k_reg     <= i_reg;
                        ov_reg    <= 1'b0;
                        state_reg <= S_E_RD1;
                    end
                end
                // row update, one column per pass
                S_E_RD1: state_reg <= S_E_RD2;
                S_E_RD2:
                begin
                    prod_reg  <= 64'(rd_data) * 64'(f_reg);
                    state_reg <= S_E_MUL;
                end
                S_E_MUL:
                begin
                    t_reg     <= rd_data;
                    state_reg <= S_E_WR;
                end
                S_E_WR:
                begin
                    if (ov_reg)
                    begin
                        // finishing a swap column
                        j_reg <= i_reg;
                        if (k_reg == n_reg)
                            state_reg <= S_PV_RD;
                        else
                        begin
                            k_reg     <= k_reg + IW'(1);
                            state_reg <= S_SWP_RD1;
                        end
                    end
                    else if (k_reg != n_reg)
                    begin
                        k_reg     <= k_reg + IW'(1);
                        state_reg <= S_E_RD1;
                    end
                    else if (j_reg != n_reg - IW'(1))
                    begin
                        j_reg     <= j_reg + IW'(1);
                        state_reg <= S_F_RD;
                    end
                    else if (i_reg + IW'(2) < n_reg)
                    begin
                        i_reg     <= i_reg + IW'(1);
                        j_reg     <= i_reg + IW'(1);
                        state_reg <= S_PIV_RD;
                    end
                    else
                    begin
                        i_reg     <= n_reg - IW'(1);
                        state_reg <= S_B_RD;
                    end
                end
                // back substitution for row i
                S_B_RD: state_reg <= S_B_CHK;
                S_B_CHK:
                begin
                    acc_reg <= rd_data;
                    j_reg   <= i_reg + IW'(1);
                    state_reg <= S_B_RD1;
                end
                S_B_RD1:
                begin
                    p_reg <= rd_data;
                    if (j_reg == n_reg)
                        state_reg <= S_B_DIV;
                    else
                        state_reg <= S_B_RD2;
                end
                S_B_RD2:
                begin
                    t_reg     <= rd_data;
                    state_reg <= S_B_MUL;
                end
                S_B_MUL:
                begin
                    prod_reg  <= 64'(t_reg) * 64'(rd_data);
                    state_reg <= S_B_SUB;
                end
                S_B_SUB:
                begin
                    acc_reg   <= sat32(64'(acc_reg) - mulq_fix(prod_reg));
                    j_reg     <= j_reg + IW'(1);
                    state_reg <= S_B_RD1;
                end
                S_B_DIV:
                begin
                    if (p_reg == 32'sd0)
                    begin
                        sing_reg  <= 1'b1;
                        i_reg     <= '0;
                        state_reg <= S_OUT_RD;
                    end
                    else
                        state_reg <= S_B_WAIT;
                end
                S_B_WAIT:
                begin
                    if (div_done)
                    begin
                        if (i_reg == '0)
                            state_reg <= S_OUT_RD;
                        else
                        begin
                            i_reg     <= i_reg - IW'(1);
                            state_reg <= S_B_RD;
                        end
                    end
                end
                // emit results in index order
                S_OUT_RD: state_reg <= S_OUT;
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        if (i_reg == n_reg - IW'(1))
                        begin
                            i_reg     <= '0;
                            state_reg <= S_LOAD;
                        end
                        else
                        begin
                            i_reg     <= i_reg + IW'(1);
                            state_reg <= S_OUT_RD;
                        end
                    end
                end
                default: state_reg <= S_LOAD;
            endcase
        end
    end

endmodule

>>> hw/rtl/gepp_div.sv
// iterative signed divider, one quotient bit per cycle, saturated result
module gepp_div (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic signed [63:0]  dividend,
    input  logic signed [31:0]  divisor,
    output logic                done,
    output logic signed [31:0]  quotient
);
    import gepp_pkg::*;

    logic [63:0] rem_reg, rem_next;
    logic [63:0] quo_reg, quo_next;
    logic [31:0] dvs_reg, dvs_next;
    logic        neg_reg, neg_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [64:0] trial;
    logic [63:0] dmag;
    logic signed [64:0] sq;
    logic [63:0] shifted;

    assign dmag    = dividend[63] ? 64'(-dividend) : 64'(dividend);
    assign shifted = {rem_reg[62:0], quo_reg[63]};
    assign trial   = {1'b0, shifted} - {33'd0, dvs_reg};
    assign sq      = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});

    // restoring division step control
    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = 64'd0;
            quo_next  = dmag;
            dvs_next  = divisor[31] ? 32'(-divisor) : 32'(divisor);
            neg_next  = dividend[63] ^ divisor[31];
            cnt_next  = 7'(DIV_STEPS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[64])
            begin
                rem_next = trial[63:0];
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 7'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    assign done = done_reg;
    // the quotient magnitude fits in 64 bits, the sign widens it to 65
    assign quotient = (sq > 65'sh0_7FFF_FFFF) ? 32'sh7FFF_FFFF :
                      (sq < -65'sh0_8000_0000) ? 32'sh8000_0000 : sq[31:0];

endmodule
